FILE: rtl/dpp_pkg.sv
// dpp_pkg: shared types and constants of the depth pixel to point pipeline
// (pixel and point words, configuration set, stage enables, stride table)
// no dependencies
package dpp_pkg;

    localparam int NUM_STAGES = 7;
    localparam int STG_IN     = 0;
    localparam int STG_MUL    = 1;
    localparam int STG_RAY    = 2;
    localparam int STG_CLAMP  = 3;
    localparam int STG_SCALE  = 4;
    localparam int STG_SUM    = 5;
    localparam int STG_OUT    = 6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_STRIDE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERSE_FOCAL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_COSINE_YAW    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SINE_YAW      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEAR_LIMIT    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAR_LIMIT     = 3'd7;

    // ceil(2^18 / stride), stride zero reads as one
    localparam int RECIP_SHIFT = 18;
    localparam logic [18:0] STRIDE_RECIP [32] = '{
        19'd262144, 19'd262144, 19'd131072, 19'd87382,
        19'd65536,  19'd52429,  19'd43691,  19'd37450,
        19'd32768,  19'd29128,  19'd26215,  19'd23832,
        19'd21846,  19'd20165,  19'd18725,  19'd17477,
        19'd16384,  19'd15421,  19'd14564,  19'd13798,
        19'd13108,  19'd12484,  19'd11916,  19'd11398,
        19'd10923,  19'd10486,  19'd10083,  19'd9710,
        19'd9363,   19'd9040,   19'd8739,   19'd8457
    };

    localparam logic [24:0] DEPTH_DIV      = 25'h0FF_FFFF;
    localparam logic [24:0] DEPTH_DIV_X2   = 25'h1FF_FFFE;
    localparam logic [47:0] DEPTH_ROUND    = 48'd8388607;
    localparam logic signed [39:0] RAY_LIMIT = 40'sh7F_FFFF_FFFF;

    typedef struct packed {
        logic [7:0]  red_byte;
        logic [7:0]  green_byte;
        logic [7:0]  blue_byte;
        logic [11:0] pixel_column;
        logic [11:0] pixel_row;
    } t_pixel;

    typedef struct packed {
        logic signed [31:0] point_forward;
        logic signed [31:0] point_left;
        logic signed [31:0] point_up;
    } t_point;

    typedef struct packed {
        logic [12:0]        image_width;
        logic [12:0]        image_height;
        logic [4:0]         sample_stride;
        logic [23:0]        inverse_focal;
        logic signed [17:0] cosine_yaw;
        logic signed [17:0] sine_yaw;
        logic [23:0]        near_limit;
        logic [23:0]        far_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        image_width:   13'd800,
        image_height:  13'd600,
        sample_stride: 5'd1,
        inverse_focal: 24'd2621,
        cosine_yaw:    18'sd65536,
        sine_yaw:      18'sd0,
        near_limit:    24'd0,
        far_limit:     24'd1638400
    };

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } t_pipe_ctl;

endpackage

FILE: rtl/dpp_ctrl.sv
// dpp_ctrl: valid bits and stage enables of the pixel pipeline
// depends on dpp_pkg
module dpp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  logic              i_keep,
    output dpp_pkg::t_pipe_ctl o_ctl,
    output logic              o_in_ready,
    output logic              o_out_valid
);
    import dpp_pkg::*;

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    logic [NUM_STAGES-1:0] en;

    // a stage loads when empty or when its word moves on
    always_comb begin
        en[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    always_comb begin
        n_valid = r_valid;
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (en[k]) begin
                if (k == STG_IN) begin
                    n_valid[k] = i_in_valid;
                end else if (k == STG_SCALE) begin
                    n_valid[k] = r_valid[k-1] && i_keep;
                end else begin
                    n_valid[k] = r_valid[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ctl.en    = en;
    assign o_in_ready  = en[STG_IN];
    assign o_out_valid = r_valid[NUM_STAGES-1];

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_valid) && !i_out_ready) |-> !o_in_ready)
        else $error("full pipeline stalled but input ready");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_in_valid && !i_out_ready && (!r_valid[STG_CLAMP] || i_keep))
        |=> ($countones(r_valid) == $past($countones(r_valid))))
        else $error("word lost or duplicated in pipeline");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_valid == '0))
        else $error("valid bits not cleared by reset");

endmodule

FILE: rtl/dpp_front.sv
// dpp_front: grid and bounds filter, depth scaling and yaw-rotated ray,
// four pipeline stages; depends on dpp_pkg
module dpp_front #(
    parameter int MAX_IMAGE_SIDE = 4096
) (
    input  logic               i_clk,
    input  dpp_pkg::t_pixel    i_pix,
    input  dpp_pkg::t_cfg      i_cfg,
    input  dpp_pkg::t_pipe_ctl i_ctl,
    output logic               o_keep,
    output logic [23:0]        o_depth,
    output logic signed [39:0] o_ray_fwd,
    output logic signed [39:0] o_ray_left,
    output logic signed [39:0] o_ray_up
);
    import dpp_pkg::*;

    function automatic logic signed [43:0] round_sh13(input logic signed [56:0] x);
        logic signed [56:0] t;
        t = x + (x[56] ? 57'sd4095 : 57'sd4096);
        return 44'(t >>> 13);
    endfunction

    function automatic logic signed [39:0] clamp_ray(input logic signed [44:0] r);
        logic signed [44:0] lim;
        lim = 45'(RAY_LIMIT);
        if (r > lim) begin
            return RAY_LIMIT;
        end else if (r < -lim) begin
            return -RAY_LIMIT;
        end else begin
            return 40'(r);
        end
    endfunction

    logic [12:0] w_clip, h_clip;
    logic [4:0]  stride;
    logic [23:0] code;

    // stage a
    logic [33:0]        r_a_code1000;
    logic signed [13:0] r_a_du, r_a_dv;
    logic [11:0]        r_a_u, r_a_v;
    logic               r_a_inb;
    // stage b
    logic [30:0]        prod_u, prod_v;
    logic [47:0]        scaled;
    logic [11:0]        r_b_qu, r_b_qv, r_b_u, r_b_v;
    logic [23:0]        r_b_hi;
    logic [24:0]        r_b_sum;
    logic signed [38:0] r_b_a21, r_b_b21;
    logic               r_b_inb;
    // stage c
    logic [23:0]        depth;
    logic               grid_ok;
    logic signed [56:0] r_c_rx, r_c_ry;
    logic signed [39:0] r_c_up;
    logic [23:0]        r_c_depth;
    logic               r_c_keep;
    // stage d
    logic signed [39:0] r_d_fwd, r_d_left, r_d_up;
    logic [23:0]        r_d_depth;
    logic               r_d_keep;

    assign w_clip = (int'(i_cfg.image_width) > MAX_IMAGE_SIDE) ?
                    13'(MAX_IMAGE_SIDE) : i_cfg.image_width;
    assign h_clip = (int'(i_cfg.image_height) > MAX_IMAGE_SIDE) ?
                    13'(MAX_IMAGE_SIDE) : i_cfg.image_height;
    assign stride = (i_cfg.sample_stride == 5'd0) ? 5'd1 : i_cfg.sample_stride;
    assign code   = {i_pix.blue_byte, i_pix.green_byte, i_pix.red_byte};

    // code times 1000 as 1024 - 16 - 8
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_IN]) begin
            r_a_code1000 <= {code, 10'b0} - 34'({code, 4'b0}) - 34'({code, 3'b0});
            r_a_du       <= $signed({1'b0, i_pix.pixel_column, 1'b0}) - $signed({1'b0, w_clip});
            r_a_dv       <= $signed({1'b0, i_pix.pixel_row, 1'b0}) - $signed({1'b0, h_clip});
            r_a_u        <= i_pix.pixel_column;
            r_a_v        <= i_pix.pixel_row;
            r_a_inb      <= ({1'b0, i_pix.pixel_column} < w_clip) &&
                            ({1'b0, i_pix.pixel_row} < h_clip);
        end
    end

    // divide by 2^24 - 1 as hi + (hi + lo) / (2^24 - 1)
    assign prod_u = 31'(r_a_u) * 31'(STRIDE_RECIP[i_cfg.sample_stride]);
    assign prod_v = 31'(r_a_v) * 31'(STRIDE_RECIP[i_cfg.sample_stride]);
    assign scaled = {r_a_code1000, 14'b0} + DEPTH_ROUND;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_MUL]) begin
            r_b_qu  <= prod_u[RECIP_SHIFT +: 12];
            r_b_qv  <= prod_v[RECIP_SHIFT +: 12];
            r_b_u   <= r_a_u;
            r_b_v   <= r_a_v;
            r_b_hi  <= scaled[47:24];
            r_b_sum <= 25'(scaled[47:24]) + 25'(scaled[23:0]);
            r_b_a21 <= 39'(r_a_du) * 39'($signed({1'b0, i_cfg.inverse_focal}));
            r_b_b21 <= 39'(r_a_dv) * 39'($signed({1'b0, i_cfg.inverse_focal}));
            r_b_inb <= r_a_inb;
        end
    end

    always_comb begin
        if (r_b_sum >= DEPTH_DIV_X2) begin
            depth = r_b_hi + 24'd2;
        end else if (r_b_sum >= DEPTH_DIV) begin
            depth = r_b_hi + 24'd1;
        end else begin
            depth = r_b_hi;
        end
        grid_ok = ((17'(r_b_qu) * 17'(stride)) == 17'(r_b_u)) &&
                  ((17'(r_b_qv) * 17'(stride)) == 17'(r_b_v));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_RAY]) begin
            r_c_rx    <= (57'(i_cfg.cosine_yaw) <<< 21) - 57'(r_b_a21) * 57'(i_cfg.sine_yaw);
            r_c_ry    <= (57'(i_cfg.sine_yaw) <<< 21) + 57'(r_b_a21) * 57'(i_cfg.cosine_yaw);
            r_c_up    <= clamp_ray(-(45'(r_b_b21) <<< 3));
            r_c_depth <= depth;
            r_c_keep  <= r_b_inb && grid_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_CLAMP]) begin
            r_d_fwd   <= clamp_ray(45'(round_sh13(r_c_rx)));
            r_d_left  <= clamp_ray(-45'(round_sh13(r_c_ry)));
            r_d_up    <= r_c_up;
            r_d_depth <= r_c_depth;
            r_d_keep  <= r_c_keep && (r_c_depth >= i_cfg.near_limit) &&
                         (r_c_depth < i_cfg.far_limit);
        end
    end

    assign o_keep     = r_d_keep;
    assign o_depth    = r_d_depth;
    assign o_ray_fwd  = r_d_fwd;
    assign o_ray_left = r_d_left;
    assign o_ray_up   = r_d_up;

endmodule

FILE: rtl/dpp_lane.sv
// dpp_lane: depth times ray for one coordinate, rounded and saturated,
// three pipeline stages; depends on dpp_pkg
module dpp_lane (
    input  logic               i_clk,
    input  dpp_pkg::t_pipe_ctl i_ctl,
    input  logic [23:0]        i_depth,
    input  logic signed [39:0] i_ray,
    output logic signed [31:0] o_coord
);
    import dpp_pkg::*;

    logic [43:0]        r_e_lo;
    logic signed [44:0] r_e_hi;
    logic signed [63:0] r_f_prod;
    logic signed [63:0] biased;
    logic signed [39:0] rounded;
    logic signed [31:0] sat;
    logic signed [31:0] r_g_coord;

    // split the ray into a signed high half and an unsigned low half
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_SCALE]) begin
            r_e_lo <= 44'(i_depth) * 44'(i_ray[19:0]);
            r_e_hi <= 45'($signed({1'b0, i_depth})) * 45'($signed(i_ray[39:20]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_SUM]) begin
            r_f_prod <= (64'(r_e_hi) <<< 20) + 64'($signed({1'b0, r_e_lo}));
        end
    end

    // round ties away from zero, then saturate
    always_comb begin
        biased  = r_f_prod + (r_f_prod[63] ? 64'sd8388607 : 64'sd8388608);
        rounded = 40'(biased >>> 24);
        if (rounded > 40'sd2147483647) begin
            sat = 32'sh7FFF_FFFF;
        end else if (rounded < -40'sd2147483648) begin
            sat = 32'sh8000_0000;
        end else begin
            sat = 32'(rounded);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[STG_OUT]) begin
            r_g_coord <= sat;
        end
    end

    assign o_coord = r_g_coord;

endmodule

FILE: rtl/depth_pixel_to_point.sv
// depth_pixel_to_point: top level, configuration registers and pipeline
// depends on dpp_pkg, dpp_ctrl, dpp_front, dpp_lane
//
//  channel   direction  handshake                      word
//  pixel     in         i_pix_valid / o_pix_ready      i_pix (t_pixel)
//  point     out        o_point_valid / i_point_ready  o_point (t_point)
//  config    in         i_cfg_we                       i_cfg_index, i_cfg_data
//
// one pixel word accepted per cycle while the output is not stalled
// the pipeline has seven register stages: input, multiply, rotate,
// round and clamp, split multiply, sum, round and saturate
// dropped pixels leave the pipeline after the fourth stage and give no word
// a stalled output holds its word; empty stages upstream keep filling
// synchronous active-low reset clears valid bits and loads register defaults
module depth_pixel_to_point #(
    parameter int MAX_IMAGE_SIDE = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_pix_valid,
    output logic                                o_pix_ready,
    input  dpp_pkg::t_pixel                     i_pix,
    output logic                                o_point_valid,
    input  logic                                i_point_ready,
    output dpp_pkg::t_point                     o_point,
    input  logic                                i_cfg_we,
    input  logic [dpp_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [dpp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import dpp_pkg::*;

    t_cfg               r_cfg;
    t_pipe_ctl          ctl;
    logic               keep;
    logic [23:0]        depth;
    logic signed [39:0] ray_fwd, ray_left, ray_up;
    logic signed [31:0] coord_fwd, coord_left, coord_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:   r_cfg.image_width   <= i_cfg_data[12:0];
                CFG_IMAGE_HEIGHT:  r_cfg.image_height  <= i_cfg_data[12:0];
                CFG_SAMPLE_STRIDE: r_cfg.sample_stride <= i_cfg_data[4:0];
                CFG_INVERSE_FOCAL: r_cfg.inverse_focal <= i_cfg_data[23:0];
                CFG_COSINE_YAW:    r_cfg.cosine_yaw    <= $signed(i_cfg_data[17:0]);
                CFG_SINE_YAW:      r_cfg.sine_yaw      <= $signed(i_cfg_data[17:0]);
                CFG_NEAR_LIMIT:    r_cfg.near_limit    <= i_cfg_data[23:0];
                CFG_FAR_LIMIT:     r_cfg.far_limit     <= i_cfg_data[23:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    dpp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix_valid),
        .i_out_ready (i_point_ready),
        .i_keep      (keep),
        .o_ctl       (ctl),
        .o_in_ready  (o_pix_ready),
        .o_out_valid (o_point_valid)
    );

    dpp_front #(
        .MAX_IMAGE_SIDE (MAX_IMAGE_SIDE)
    ) u_front (
        .i_clk      (i_clk),
        .i_pix      (i_pix),
        .i_cfg      (r_cfg),
        .i_ctl      (ctl),
        .o_keep     (keep),
        .o_depth    (depth),
        .o_ray_fwd  (ray_fwd),
        .o_ray_left (ray_left),
        .o_ray_up   (ray_up)
    );

    dpp_lane u_lane_fwd (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_depth (depth),
        .i_ray   (ray_fwd),
        .o_coord (coord_fwd)
    );

    dpp_lane u_lane_left (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_depth (depth),
        .i_ray   (ray_left),
        .o_coord (coord_left)
    );

    dpp_lane u_lane_up (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_depth (depth),
        .i_ray   (ray_up),
        .o_coord (coord_up)
    );

    assign o_point = '{point_forward: coord_fwd,
                       point_left:    coord_left,
                       point_up:      coord_up};

endmodule
